@@ sv/fenwick_point_update_range_sum_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Fenwick range-sum block
// Shared concurrent assertion forms, all clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FENWICK_POINT_UPDATE_RANGE_SUM_TOP_ASSERT_SVH
`define FENWICK_POINT_UPDATE_RANGE_SUM_TOP_ASSERT_SVH

// Same-cycle implication.
`define FWK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FWK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fwk_pkg.sv @@
// ----------------------------------------------------------------------------
// Fenwick range-sum package
// Field widths, item codes and the structs passed between the top level
// and the tree engine.
// ----------------------------------------------------------------------------
package fwk_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 42;

  // Item kinds.
  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One accepted input item.
  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        left;
    logic [IDX_W-1:0]        right;
  } cmd_t;

  // Engine status toward the top level.
  typedef struct packed {
    logic busy;
    logic res_valid;
  } stat_t;

endpackage

@@ sv/fwk_engine.sv @@
// ----------------------------------------------------------------------------
// Fenwick tree engine
// Holds the tree node memory and the element memory, clears both after
// reset, and walks the lowbit chain one node at a time for updates and
// range-sum queries.
// ----------------------------------------------------------------------------
`include "fenwick_point_update_range_sum_top_assert.svh"

module fwk_engine #(
  parameter int SIZE = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  fwk_pkg::cmd_t                       cmd,
  input  logic                                res_take,
  output fwk_pkg::stat_t                      stat,
  output logic signed [fwk_pkg::SUM_W-1:0]    res_sum
);

  localparam int AW = $clog2(SIZE);
  localparam int PW = $clog2(SIZE + 1);
  localparam int CW = (PW + 1 > fwk_pkg::IDX_W + 1) ? PW + 1 : fwk_pkg::IDX_W + 1;
  localparam int EXT_W = fwk_pkg::SUM_W - fwk_pkg::VAL_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ELEM_RD,
    S_ELEM_WB,
    S_UPD_RD,
    S_UPD_WR,
    S_QUERY,
    S_DONE
  } state_t;

  state_t                   state;
  fwk_pkg::cmd_t            cmd_hold;
  logic [AW-1:0]            clr_addr;
  logic [PW:0]              pos;
  logic                     neg;
  logic                     pend;
  logic [fwk_pkg::SUM_W-1:0] acc;
  logic [fwk_pkg::SUM_W-1:0] delta;

  // Memories and their read data.
  logic [fwk_pkg::SUM_W-1:0] tree_mem [SIZE];
  logic [fwk_pkg::VAL_W-1:0] elem_mem [SIZE];
  logic [fwk_pkg::SUM_W-1:0] tree_rdata;
  logic [fwk_pkg::VAL_W-1:0] elem_rdata;

  logic                      tree_we;
  logic [AW-1:0]             tree_waddr;
  logic [fwk_pkg::SUM_W-1:0] tree_wdata;
  logic                      elem_we;
  logic [AW-1:0]             elem_addr;
  logic [fwk_pkg::VAL_W-1:0] elem_wdata;

  // Position arithmetic along the lowbit chain.
  logic [PW:0]     pos_m1;
  logic [AW-1:0]   pos_addr;
  logic [PW:0]     pos_low;
  logic [PW:0]     pos_up;
  logic [PW:0]     pos_down;
  logic [CW-1:0]   idx_ext;
  logic [CW-1:0]   idx_p1;
  logic [CW-1:0]   right_p1;
  logic [CW-1:0]   right_clamp;
  logic [CW-1:0]   left_ext;
  logic [CW-1:0]   left_clamp;
  logic            idx_ok;
  logic [fwk_pkg::SUM_W-1:0] new_ext;
  logic [fwk_pkg::SUM_W-1:0] old_ext;

  assign pos_m1   = pos - (PW + 1)'(1);
  assign pos_addr = pos_m1[AW-1:0];
  assign pos_low  = pos & (~pos + (PW + 1)'(1));
  assign pos_up   = pos + pos_low;
  assign pos_down = pos - pos_low;

  assign idx_ext     = CW'(cmd_hold.index);
  assign idx_p1      = idx_ext + CW'(1);
  assign idx_ok      = CW'(cmd.index) < CW'(SIZE);
  assign right_p1    = CW'(cmd.right) + CW'(1);
  assign right_clamp = (right_p1 > CW'(SIZE)) ? CW'(SIZE) : right_p1;
  assign left_ext    = CW'(cmd_hold.left);
  assign left_clamp  = (left_ext > CW'(SIZE)) ? CW'(SIZE) : left_ext;

  assign new_ext = {{EXT_W{cmd_hold.value[fwk_pkg::VAL_W-1]}}, cmd_hold.value};
  assign old_ext = {{EXT_W{elem_rdata[fwk_pkg::VAL_W-1]}}, elem_rdata};

  // Memory port control: the clearing sweep owns both write ports.
  assign tree_we    = (state == S_CLEAR) || (state == S_UPD_WR);
  assign tree_waddr = (state == S_CLEAR) ? clr_addr : pos_addr;
  assign tree_wdata = (state == S_CLEAR) ? '0 : tree_rdata + delta;
  assign elem_we    = (state == S_CLEAR) || (state == S_ELEM_WB);
  assign elem_addr  = (state == S_CLEAR) ? clr_addr : idx_ext[AW-1:0];
  assign elem_wdata = (state == S_CLEAR) ? '0 : cmd_hold.value;

  // Tree node memory: node p lives at address p - 1.
  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_rdata <= tree_mem[pos_addr];
  end

  // Element copy memory.
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_addr] <= elem_wdata;
    end
    elem_rdata <= elem_mem[elem_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pos      <= '0;
      neg      <= 1'b0;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_hold <= cmd;
            if (cmd.kind == fwk_pkg::KIND_QUERY) begin
              pos   <= right_clamp[PW:0];
              neg   <= 1'b0;
              pend  <= 1'b0;
              acc   <= '0;
              state <= S_QUERY;
            end else if (idx_ok) begin
              state <= S_ELEM_RD;
            end
          end
        end
        S_ELEM_RD: begin
          state <= S_ELEM_WB;
        end
        S_ELEM_WB: begin
          delta <= new_ext - old_ext;
          pos   <= idx_p1[PW:0];
          state <= S_UPD_RD;
        end
        S_UPD_RD: begin
          state <= S_UPD_WR;
        end
        S_UPD_WR: begin
          pos <= pos_up;
          if (pos_up > (PW + 1)'(SIZE)) begin
            state <= S_IDLE;
          end else begin
            state <= S_UPD_RD;
          end
        end
        S_QUERY: begin
          // Accumulate the node read in the previous cycle.
          if (pend) begin
            acc <= neg ? acc - tree_rdata : acc + tree_rdata;
          end
          if (pos != '0) begin
            pos  <= pos_down;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (!neg) begin
                neg <= 1'b1;
                pos <= left_clamp[PW:0];
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.busy      = (state != S_IDLE);
  assign stat.res_valid = (state == S_DONE);
  assign res_sum        = acc;

  // Checks on the sequencer.
  `FWK_ASSERT_IMP(a_start_idle, clk, rst, start, state == S_IDLE,
    "item started while the engine was busy")
  `FWK_ASSERT_IMP(a_walk_pos, clk, rst, state == S_UPD_WR, pos != '0,
    "update walk reached node zero")
  `FWK_ASSERT_NEXT(a_hold_result, clk, rst, state == S_DONE && !res_take,
    state == S_DONE, "result dropped before transfer")
  `FWK_ASSERT_NEXT(a_query_end, clk, rst,
    state == S_QUERY && pos == '0 && !pend && neg, state == S_DONE,
    "query did not finish after both prefix walks")

endmodule

@@ sv/fenwick_point_update_range_sum_top.sv @@
// An update reads and writes each node on the upward chain, at most log2(SIZE)+1 nodes.
// A query walks the prefix chains from right+1 and from left, and subtracts the second sum.
// With the output register free, a new item can be taken in the cycle after the result moves out.
// The tree memory has a single read port; the engine takes one item at a time.
// After reset, in_stall stays high while both memories are swept to zero.
// Results wait in an output register, so a taken result frees the engine even while out_stall holds it.
// ----------------------------------------------------------------------------
// Fenwick range-sum top level
// Binary indexed tree with point updates and inclusive range-sum queries,
// valid/stall channels on input and output.
// ----------------------------------------------------------------------------
module fenwick_point_update_range_sum_top #(
  parameter int SIZE = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [fwk_pkg::IDX_W-1:0]          index,
  input  logic signed [fwk_pkg::VAL_W-1:0]   value,
  input  logic [fwk_pkg::IDX_W-1:0]          left,
  input  logic [fwk_pkg::IDX_W-1:0]          right,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fwk_pkg::SUM_W-1:0]   range_sum
);

  fwk_pkg::cmd_t                      cmd;
  fwk_pkg::stat_t                     stat;
  logic                               start;
  logic                               res_take;
  logic signed [fwk_pkg::SUM_W-1:0]   res_sum;

  // Input transfer starts the engine.
  assign cmd.kind  = kind;
  assign cmd.index = index;
  assign cmd.value = value;
  assign cmd.left  = left;
  assign cmd.right = right;
  assign in_stall  = stat.busy;
  assign start     = in_valid && !in_stall;

  // A finished sum moves to the output register once it is free.
  assign res_take = stat.res_valid && (!out_valid || !out_stall);

  fwk_engine #(
    .SIZE(SIZE)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .res_take (res_take),
    .stat     (stat),
    .res_sum  (res_sum)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      range_sum <= res_sum;
    end
  end

endmodule
